[hdl/wavetable_sound_channel_unit_defines.svh]
// Assertion macros shared by the wavetable channel RTL.
`ifndef WAVETABLE_SOUND_CHANNEL_UNIT_DEFINES_SVH
`define WAVETABLE_SOUND_CHANNEL_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/wsc_pkg.sv]
// Shared types and constants for the wavetable sound channel.
`timescale 1ns / 1ps
package wsc_pkg;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_LEN_TICK  = 3'd1,
    ACT_REG_WRITE = 3'd2,
    ACT_REG_READ  = 3'd3,
    ACT_WAVE_WR   = 3'd4,
    ACT_WAVE_RD   = 3'd5
  } action_t;

  localparam logic [3:0] REG_DAC    = 4'd0;
  localparam logic [3:0] REG_LENGTH = 4'd1;
  localparam logic [3:0] REG_VOLUME = 4'd2;
  localparam logic [3:0] REG_FREQ_LO = 4'd3;
  localparam logic [3:0] REG_CTRL   = 4'd4;

  localparam int WAVE_DEPTH = 16;
  localparam int WAVE_AW    = 4;
  localparam logic [7:0] READ_OPEN = 8'hFF;

  // Reload value of the wave timer: (2048 - freq) * 2, 13 bits.
  function automatic logic [12:0] timer_period(input logic [10:0] freq);
    logic [11:0] diff;
    diff = 12'd2048 - {1'b0, freq};
    return {diff, 1'b0};
  endfunction

endpackage

[hdl/wsc_wave_ram.sv]
// 16-byte wave RAM with a write port and two registered read ports.
`timescale 1ns / 1ps
module wsc_wave_ram
  import wsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [WAVE_AW-1:0] wr_addr,
  input  logic [7:0]         wr_data,
  input  logic               a_en,
  input  logic [WAVE_AW-1:0] a_addr,
  output logic [7:0]         a_data,
  input  logic               b_en,
  input  logic [WAVE_AW-1:0] b_addr,
  output logic [7:0]         b_data
);

  logic [7:0]            mem [WAVE_DEPTH];
  logic [WAVE_DEPTH-1:0] valid_r;
  logic [7:0]            a_data_r;
  logic [7:0]            b_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      a_data_r <= '0;
      b_data_r <= '0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (a_en) begin
        a_data_r <= valid_r[a_addr] ? mem[a_addr] : 8'h00;
      end
      if (b_en) begin
        b_data_r <= valid_r[b_addr] ? mem[b_addr] : 8'h00;
      end
    end
  end

  assign a_data = a_data_r;
  assign b_data = b_data_r;

endmodule

[hdl/wavetable_sound_channel_unit.sv]
// Top level of the wavetable sound channel.
// The channel takes one action per transfer and returns exactly one result per action.
// An action is accepted in every cycle in which the output register is empty or being
// drained, so the sustained rate is one action per clock unless the output stalls; the
// result appears in the output register in the cycle after its action is accepted.
// Register state and the wave RAM are updated at the accepting edge, and wave RAM reads
// land in that RAM's registered read ports, which double as the sample latch and the read-back data.
`timescale 1ns / 1ps
`include "wavetable_sound_channel_unit_defines.svh"
module wavetable_sound_channel_unit
  import wsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] addr, [11:4] data, [18:12] tick_cycles, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [3:0] sample, [11:4] read_data, rest zero
);

  logic [3:0]  in_addr;
  logic [7:0]  in_data;
  logic [6:0]  in_cycles;
  logic        accept;

  logic        dac_on_r, dac_on_nxt;
  logic        chan_en_r, chan_en_nxt;
  logic [8:0]  len_left_r, len_left_nxt;
  logic        len_on_r, len_on_nxt;
  logic [1:0]  vol_r, vol_nxt;
  logic [10:0] freq_r, freq_nxt;
  logic [12:0] count_r, count_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic        lat_lo_r, lat_lo_nxt;

  logic        out_valid_r;
  logic [3:0]  out_smp_r, out_smp_nxt;
  logic [7:0]  out_rd_r, out_rd_nxt;
  logic        out_wave_r, out_wave_nxt;

  logic        expire;
  logic [3:0]  latch_nib;
  logic [3:0]  level;
  logic [7:0]  lat_byte;
  logic [7:0]  wave_rd;
  logic        ram_wr;
  logic        ram_a_en;
  logic        ram_b_en;

  assign in_addr   = in_tdata[3:0];
  assign in_data   = in_tdata[11:4];
  assign in_cycles = in_tdata[18:12];

  // no transfer is taken while reset is held
  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  assign expire    = ({6'd0, in_cycles} >= count_r);
  assign latch_nib = lat_lo_r ? lat_byte[3:0] : lat_byte[7:4];

  always_comb begin
    level = 4'd0;
    if (chan_en_r) begin
      case (vol_r)
        2'd1:    level = latch_nib;
        2'd2:    level = latch_nib >> 1;
        2'd3:    level = latch_nib >> 2;
        default: level = 4'd0;
      endcase
    end
  end

  assign ram_wr   = accept && (in_tuser == ACT_WAVE_WR);
  assign ram_b_en = accept && (in_tuser == ACT_WAVE_RD);
  assign ram_a_en = accept && (in_tuser == ACT_TICK) && expire;

  wsc_wave_ram u_wave_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ram_wr),
    .wr_addr (in_addr),
    .wr_data (in_data),
    .a_en    (ram_a_en),
    .a_addr  (pos_nxt[4:1]),
    .a_data  (lat_byte),
    .b_en    (ram_b_en),
    .b_addr  (in_addr),
    .b_data  (wave_rd)
  );

  always_comb begin
    dac_on_nxt   = dac_on_r;
    chan_en_nxt  = chan_en_r;
    len_left_nxt = len_left_r;
    len_on_nxt   = len_on_r;
    vol_nxt      = vol_r;
    freq_nxt     = freq_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    lat_lo_nxt   = lat_lo_r;
    out_smp_nxt  = 4'd0;
    out_rd_nxt   = 8'd0;
    out_wave_nxt = 1'b0;
    case (in_tuser)
      ACT_TICK: begin
        out_smp_nxt = level;
        if (expire) begin
          count_nxt  = timer_period(freq_r);
          pos_nxt    = pos_r + 5'd1;
          lat_lo_nxt = pos_nxt[0];
        end else begin
          count_nxt = count_r - {6'd0, in_cycles};
        end
      end
      ACT_LEN_TICK: begin
        if (len_on_r && (len_left_r != 9'd0)) begin
          len_left_nxt = len_left_r - 9'd1;
          if (len_left_r == 9'd1) begin
            chan_en_nxt = 1'b0;
          end
        end
      end
      ACT_REG_WRITE: begin
        case (in_addr)
          REG_DAC: begin
            dac_on_nxt  = in_data[7];
            chan_en_nxt = chan_en_r && in_data[7];
          end
          REG_LENGTH:  len_left_nxt = 9'd256 - {1'b0, in_data};
          REG_VOLUME:  vol_nxt = in_data[6:5];
          REG_FREQ_LO: freq_nxt = {freq_r[10:8], in_data};
          REG_CTRL: begin
            freq_nxt   = {in_data[2:0], freq_r[7:0]};
            len_on_nxt = in_data[6];
            if (in_data[7]) begin
              // trigger: restart the voice, keep the latched sample
              chan_en_nxt = dac_on_r;
              if (len_left_r == 9'd0) begin
                len_left_nxt = 9'd256;
                len_on_nxt   = 1'b0;
              end
              count_nxt = timer_period(freq_nxt);
              pos_nxt   = 5'd0;
            end
          end
          default: ;
        endcase
      end
      ACT_REG_READ: begin
        case (in_addr)
          REG_DAC:    out_rd_nxt = {dac_on_r, 7'd0};
          REG_VOLUME: out_rd_nxt = {1'b0, vol_r, 5'd0};
          REG_CTRL:   out_rd_nxt = {1'b0, len_on_r, 6'd0};
          default:    out_rd_nxt = READ_OPEN;
        endcase
      end
      ACT_WAVE_RD: out_wave_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dac_on_r    <= 1'b0;
      chan_en_r   <= 1'b0;
      len_left_r  <= '0;
      len_on_r    <= 1'b0;
      vol_r       <= '0;
      freq_r      <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      lat_lo_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_wave_r  <= 1'b0;
    end else begin
      if (accept) begin
        dac_on_r   <= dac_on_nxt;
        chan_en_r  <= chan_en_nxt;
        len_left_r <= len_left_nxt;
        len_on_r   <= len_on_nxt;
        vol_r      <= vol_nxt;
        freq_r     <= freq_nxt;
        count_r    <= count_nxt;
        pos_r      <= pos_nxt;
        lat_lo_r   <= lat_lo_nxt;
        out_wave_r <= out_wave_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_smp_r <= out_smp_nxt;
      out_rd_r  <= out_rd_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, (out_wave_r ? wave_rd : out_rd_r), out_smp_r};

  `WSC_ASSERT_NOW(a_stall_blocks_in, clk, rst_n, out_valid_r && !out_tready, !in_tready, "input taken while result stalled")
  `WSC_ASSERT_NOW(a_dac_gates_chan, clk, rst_n, !dac_on_r, !chan_en_r, "channel enabled with DAC off")
  `WSC_ASSERT_NEXT(a_expire_reload, clk, rst_n, accept && (in_tuser == ACT_TICK) && expire, count_r == timer_period(freq_r), "timer did not reload on expiry")
  `WSC_ASSERT_NEXT(a_accept_gives_out, clk, rst_n, accept, out_valid_r, "accepted action gave no result")

endmodule

[tb/testbench.sv]
// Self-checking testbench for wavetable_sound_channel_unit with a scoreboard-based channel predictor.
`timescale 1ns / 1ps
module testbench
  import wsc_pkg::*;
;

  // Action codes outside the enum; the block must ignore them.
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  typedef struct packed {
    logic [3:0] sample;
    logic [7:0] read_data;
  } chan_result_t;

  class wave_channel_scoreboard;
    logic       dac_on;
    logic       chan_on;
    logic [8:0] len_left;
    logic       len_on;
    logic [1:0] vol;
    logic [10:0] freq;
    logic [12:0] countdown;
    logic [4:0] pos;
    logic [3:0] latch;
    logic [7:0] wave_mem [16];
    chan_result_t results_due[$];
    int errors;

    function new();
      dac_on = 1'b0;
      chan_on = 1'b0;
      len_left = '0;
      len_on = 1'b0;
      vol = '0;
      freq = '0;
      countdown = '0;
      pos = '0;
      latch = '0;
      foreach (wave_mem[i]) wave_mem[i] = 8'h00;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function logic [12:0] reload_value();
      return 13'((2048 - int'(freq)) * 2);
    endfunction

    // Apply one accepted transfer to the channel copy and return the level/readback it yields.
    function chan_result_t predict_action(logic [2:0] act, logic [3:0] addr,
                                          logic [7:0] data, logic [6:0] cyc);
      chan_result_t r;
      logic [7:0] b;
      r = '0;
      case (act)
        ACT_TICK: begin
          if (chan_on && vol != 2'd0) r.sample = latch >> (vol - 1);
          if (int'(cyc) >= int'(countdown)) begin
            // overshoot drops the excess cycles
            countdown = reload_value();
            pos = pos + 5'd1;
            b = wave_mem[pos[4:1]];
            latch = pos[0] ? b[3:0] : b[7:4];
          end else begin
            countdown = countdown - 13'(cyc);
          end
        end
        ACT_LEN_TICK: begin
          if (len_on && len_left != 9'd0) begin
            len_left = len_left - 9'd1;
            if (len_left == 9'd0) chan_on = 1'b0;
          end
        end
        ACT_REG_WRITE: begin
          case (addr)
            REG_DAC: begin
              dac_on = data[7];
              chan_on = chan_on & dac_on;
            end
            REG_LENGTH: len_left = 9'd256 - {1'b0, data};
            REG_VOLUME: vol = data[6:5];
            REG_FREQ_LO: freq[7:0] = data;
            REG_CTRL: begin
              freq[10:8] = data[2:0];
              len_on = data[6];
              if (data[7]) begin
                chan_on = dac_on;
                if (len_left == 9'd0) begin
                  len_left = 9'd256;
                  len_on = 1'b0;
                end
                countdown = reload_value();
                pos = '0;
              end
            end
            default: ;
          endcase
        end
        ACT_REG_READ: begin
          case (addr)
            REG_DAC: r.read_data = dac_on ? 8'h80 : 8'h00;
            REG_VOLUME: r.read_data = {1'b0, vol, 5'd0};
            REG_CTRL: r.read_data = len_on ? 8'h40 : 8'h00;
            default: r.read_data = READ_OPEN;
          endcase
        end
        ACT_WAVE_WR: wave_mem[addr] = data;
        ACT_WAVE_RD: r.read_data = wave_mem[addr];
        default: ;
      endcase
      return r;
    endfunction

    function void note_action(logic [2:0] act, logic [3:0] addr, logic [7:0] data,
                              logic [6:0] cyc);
      results_due.push_back(predict_action(act, addr, data, cyc));
    endfunction

    task check_output(logic [15:0] word);
      chan_result_t want;
      if (results_due.size() == 0) begin
        report($sformatf("unexpected result 0x%04h", word));
      end else begin
        want = results_due.pop_front();
        if (word[3:0] !== want.sample)
          report($sformatf("sample got %0h want %0h", word[3:0], want.sample));
        if (word[11:4] !== want.read_data)
          report($sformatf("read_data got %02h want %02h", word[11:4], want.read_data));
      end
    endtask

    function int pending();
      return results_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [3:0] addr, [11:4] data, [18:12] tick_cycles, rest zero
  logic [2:0]  in_tuser = '0;   // [2:0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [3:0] sample, [11:4] read_data, rest zero

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int actions_done = 0;
  wave_channel_scoreboard sb = new();

  wavetable_sound_channel_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(1, 100) > recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata);
  end

  initial begin
    #2_000_000;
    $display("[wavetable_sound_channel_unit] ERROR");
    $finish;
  end

  // Entered and left at a falling edge.
  task automatic send(logic [2:0] act, logic [3:0] addr, logic [7:0] data, logic [6:0] cyc);
    while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = act;
    in_tdata = {5'd0, cyc, data, addr};
    do @(posedge clk); while (!in_tready);
    sb.note_action(act, addr, data, cyc);
    if (act <= ACT_WAVE_RD && !(act == ACT_REG_WRITE && addr > REG_CTRL)) actions_done++;
    @(negedge clk);
  endtask

  function automatic logic [6:0] rand_cycles();
    return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(1, 16));
  endfunction

  task automatic directed_actions();
    send(ACT_TICK, 4'd0, 8'h00, 7'd0);   // countdown is zero after reset
    for (int a = 0; a <= 4; a++) send(ACT_REG_READ, 4'(a), 8'h00, 7'd1);
    send(ACT_REG_READ, 4'hF, 8'h00, 7'd1);
    send(ACT_WAVE_WR, 4'h0, 8'hFF, 7'd1);
    send(ACT_WAVE_WR, 4'hF, 8'h00, 7'd1);
    send(ACT_WAVE_WR, 4'h1, 8'h5A, 7'd1);
    send(ACT_WAVE_RD, 4'hF, 8'h00, 7'd1);
    send(ACT_REG_WRITE, REG_DAC, 8'h80, 7'd1);
    send(ACT_REG_WRITE, REG_VOLUME, 8'h20, 7'd1);
    send(ACT_REG_WRITE, REG_FREQ_LO, 8'hFF, 7'd1);
    send(ACT_REG_WRITE, REG_CTRL, 8'hC7, 7'd1);   // trigger with length at zero
    send(ACT_TICK, 4'd0, 8'h00, 7'd127);
    send(ACT_TICK, 4'd0, 8'h00, 7'd64);
    send(ACT_TICK, 4'd0, 8'h00, 7'd1);
    send(ACT_TICK, 4'd0, 8'h00, 7'd0);
    send(ACT_REG_WRITE, REG_VOLUME, 8'h60, 7'd1);
    send(ACT_TICK, 4'd0, 8'h00, 7'd1);
    send(ACT_REG_WRITE, REG_LENGTH, 8'hFF, 7'd1);
    send(ACT_REG_WRITE, REG_CTRL, 8'h47, 7'd1);
    send(ACT_LEN_TICK, 4'd0, 8'h00, 7'd1);        // length runs out
    send(ACT_TICK, 4'd0, 8'h00, 7'd1);
    send(ACT_REG_WRITE, REG_CTRL, 8'h80, 7'd1);
    send(ACT_REG_WRITE, REG_DAC, 8'h00, 7'd1);     // DAC off drops the channel
    send(ACT_TICK, 4'd0, 8'h00, 7'd1);
    send(ACT_REG_WRITE, 4'h9, 8'hFF, 7'd1);
    send(ACT_RSVD6, 4'h0, 8'h00, 7'd0);
    send(ACT_RSVD7, 4'hF, 8'hFF, 7'h7F);
  endtask

  // Mostly setup-trigger-play sequences so the wave position actually advances.
  task automatic random_actions(int count);
    int target;
    int kind;
    target = actions_done + count;
    while (actions_done < target) begin
      if ($urandom_range(0, 9) < 8) begin
        send(ACT_REG_WRITE, REG_DAC,
             ($urandom_range(0, 7) != 0) ? {1'b1, 7'($urandom)} : 8'($urandom), 7'd1);
        send(ACT_REG_WRITE, REG_VOLUME, 8'($urandom), 7'd1);
        repeat ($urandom_range(0, 3))
          send(ACT_WAVE_WR, 4'($urandom), 8'($urandom), rand_cycles());
        send(ACT_REG_WRITE, REG_FREQ_LO,
             ($urandom_range(0, 3) != 0) ? {2'b11, 6'($urandom)} : 8'($urandom), 7'd1);
        if ($urandom_range(0, 1) == 1)
          send(ACT_REG_WRITE, REG_LENGTH,
               ($urandom_range(0, 1) == 1) ? {4'hF, 4'($urandom)} : 8'($urandom), 7'd1);
        send(ACT_REG_WRITE, REG_CTRL,
             {($urandom_range(0, 7) != 0), 1'($urandom), 3'($urandom),
              ($urandom_range(0, 3) != 0) ? 3'd7 : 3'($urandom)}, 7'd1);
        repeat ($urandom_range(4, 40)) begin
          kind = $urandom_range(0, 19);
          if (kind < 14)
            send(ACT_TICK, 4'($urandom), 8'($urandom), rand_cycles());
          else if (kind == 14 || kind == 19)
            send(ACT_LEN_TICK, 4'($urandom), 8'($urandom), rand_cycles());
          else if (kind == 15)
            send(ACT_REG_READ, 4'($urandom_range(0, 5)), 8'($urandom), rand_cycles());
          else if (kind == 16)
            send(ACT_WAVE_RD, 4'($urandom), 8'($urandom), rand_cycles());
          else if (kind == 17)
            send(ACT_WAVE_WR, 4'($urandom), 8'($urandom), rand_cycles());
          else
            send(ACT_REG_WRITE, 4'($urandom_range(0, 4)), 8'($urandom), rand_cycles());
        end
      end else begin
        repeat ($urandom_range(1, 5))
          send(3'($urandom), 4'($urandom), 8'($urandom), 7'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    directed_actions();
    random_actions(500);
    send_idle_pct = 50;
    random_actions(500);
    send_idle_pct = 0;
    recv_stall_pct = 50;
    random_actions(500);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    random_actions(500);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("[wavetable_sound_channel_unit] OK");
    end else begin
      $display("[wavetable_sound_channel_unit] ERROR");
    end
    $finish;
  end

endmodule
